### src/assert_macros.svh
// Assertion macros used by the checker of the ring log drain.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on the rising clock edge, disabled while reset is high.
`define ORLD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Condition in one cycle implies an expectation in the following cycle.
`define ORLD_ASSERT_NEXT(label, cond, goal, msg) \
  `ORLD_ASSERT(label, (cond) |=> (goal), msg)

`endif

### src/orld_pkg.sv
// Types, constants and helper functions of the overwriting ring log drain.
package orld_pkg;

  localparam int SLOT_COUNT = 16;
  localparam int ENTRY_BITS = 32;
  localparam int RESULT_CAP = 16;

  // Slots that can really be used, and the width actually kept per entry.
  localparam int SLOT_LIMIT = (SLOT_COUNT < RESULT_CAP) ? SLOT_COUNT : RESULT_CAP;
  localparam int ENTRY_OUT_W = 32;
  localparam int STORE_W = (ENTRY_BITS < ENTRY_OUT_W) ? ENTRY_BITS : ENTRY_OUT_W;

  localparam int PTR_W = $clog2(SLOT_LIMIT);
  localparam int CNT_W = $clog2(SLOT_LIMIT + 1);
  localparam int CFG_W = 5;
  localparam int SLOT_OUT_W = 4;

  localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(16);

  typedef enum logic [1:0] {
    OP_APPEND    = 2'd0,
    OP_DRAIN_NEW = 2'd1,
    OP_DRAIN_ALL = 2'd2,
    OP_CLEAR     = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    KIND_APPEND_DONE = 2'd0,
    KIND_DRAINED     = 2'd1,
    KIND_EMPTY       = 2'd2,
    KIND_CLEAR_DONE  = 2'd3
  } kind_t;

  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] entry_value;
  } in_item_t;

  typedef struct packed {
    logic [1:0]            result_kind;
    logic [SLOT_OUT_W-1:0] slot;
    logic [ENTRY_OUT_W-1:0] entry_out;
    logic                  last_of_run;
  } out_item_t;

  // Requests from the sequencer to the entry store.
  typedef struct packed {
    logic               wr_en;
    logic [PTR_W-1:0]   wr_addr;
    logic [STORE_W-1:0] wr_data;
    logic               rd_en;
    logic [PTR_W-1:0]   rd_addr;
    logic               clr;
  } store_req_t;

  // Effective slot count: zero counts as one, large values saturate.
  function automatic logic [CNT_W-1:0] slot_total(input logic [CFG_W-1:0] s);
    if (s == '0) begin
      return CNT_W'(1);
    end else if (s > CFG_W'(SLOT_LIMIT)) begin
      return CNT_W'(SLOT_LIMIT);
    end else begin
      return CNT_W'(s);
    end
  endfunction

  // Next ring position, wrapping at the effective slot count.
  function automatic logic [PTR_W-1:0] ptr_advance(input logic [PTR_W-1:0] p,
                                                   input logic [CNT_W-1:0] n);
    logic [CNT_W-1:0] s;
    s = CNT_W'(p) + CNT_W'(1);
    if (s >= n) begin
      return '0;
    end else begin
      return PTR_W'(s);
    end
  endfunction

endpackage

### src/overwriting_ring_log_drain.sv
// Append, clear and empty-drain results are valid the cycle after acceptance.
// An accepted drain enters its run state, then shows one entry per cycle unless stalled.
// One append or clear per cycle while the result is free; a drain stalls input until done.
// The drain rate is set by the single read port of the entry store.
// Reset is synchronous: pointers, overrun flag and all entry valid bits clear together,
// so no clearing sweep follows; slots_in_use returns to 16.

// Top level of the overwriting ring log drain.
module overwriting_ring_log_drain import orld_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  in_item_t         in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output out_item_t        out_data,
  input  logic             cfg_wr_en,
  input  logic [CFG_W-1:0] cfg_wr_data
);

  // The sequencer owns all pointers and the result register. Each input
  // transaction is accepted only while no drain run is in progress and the
  // result register is empty or being taken, so results never overlap.
  store_req_t         store_req;
  logic [STORE_W-1:0] rd_data;

  orld_seq u_seq (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .store_req   (store_req),
    .rd_data     (rd_data)
  );

  // The store holds the entry values. Its read register doubles as the
  // entry field of the result, and it is only reloaded when the result
  // register advances, so a stalled result keeps its payload.
  orld_store u_store (
    .clk     (clk),
    .rst     (rst),
    .req     (store_req),
    .rd_data (rd_data)
  );

endmodule

### src/orld_store.sv
// Entry store: synchronous RAM with registered read and per-entry valid bits.
module orld_store import orld_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  store_req_t         req,
  output logic [STORE_W-1:0] rd_data
);

  logic [STORE_W-1:0] mem [SLOT_LIMIT];
  logic [SLOT_LIMIT-1:0] vld;
  logic [STORE_W-1:0] rdata;
  logic rvld;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rdata <= mem[req.rd_addr];
      rvld  <= vld[req.rd_addr];
    end
  end

  // An entry never written since reset or clear reads as zero.
  always_ff @(posedge clk) begin
    if (rst || req.clr) begin
      vld <= '0;
    end else if (req.wr_en) begin
      vld[req.wr_addr] <= 1'b1;
    end
  end

  assign rd_data = rvld ? rdata : '0;

endmodule

### src/orld_seq.sv
// Sequencer: ring pointers, slot count register, drain runs and result register.
module orld_seq import orld_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  in_item_t           in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output out_item_t          out_data,
  input  logic               cfg_wr_en,
  input  logic [CFG_W-1:0]   cfg_wr_data,
  output store_req_t         store_req,
  input  logic [STORE_W-1:0] rd_data
);

  typedef enum logic {
    IDLE,
    RUN
  } state_t;

  state_t state;
  logic [CFG_W-1:0] slots_in_use;
  logic [PTR_W-1:0] write_pointer;
  logic [PTR_W-1:0] handled_pointer;
  logic             overrun_flag;
  logic [PTR_W-1:0] cur;
  logic [CNT_W-1:0] cnt;
  kind_t            out_kind;
  logic [PTR_W-1:0] out_slot;
  logic             out_last;

  logic [CNT_W-1:0] n;
  logic [CNT_W-1:0] cfg_n;
  logic [PTR_W-1:0] wp_adv;
  logic             ov_new;
  logic             out_free;
  logic             accept;
  logic             drain_empty;
  logic             res_load;
  op_t              op;

  assign n        = slot_total(slots_in_use);
  assign cfg_n    = slot_total(cfg_wr_data);
  assign wp_adv   = ptr_advance(write_pointer, n);
  assign ov_new   = overrun_flag || (wp_adv == handled_pointer);
  assign out_free = !out_valid || !out_stall;
  assign in_stall = !((state == IDLE) && out_free);
  assign accept   = in_valid && !in_stall;
  assign op       = op_t'(in_data.op);

  // A drain of new entries with nothing unhandled answers with a single empty result.
  assign drain_empty = (write_pointer == handled_pointer) && !overrun_flag;

  // The result register is loaded on this edge.
  assign res_load = (accept && ((op == OP_APPEND) || (op == OP_CLEAR) ||
                                ((op == OP_DRAIN_NEW) && drain_empty))) ||
                    ((state == RUN) && out_free);

  always_comb begin
    store_req.wr_en   = accept && (op == OP_APPEND);
    store_req.wr_addr = write_pointer;
    store_req.wr_data = in_data.entry_value[STORE_W-1:0];
    store_req.rd_en   = (state == RUN) && out_free;
    store_req.rd_addr = cur;
    store_req.clr     = accept && (op == OP_CLEAR);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= IDLE;
      out_valid       <= 1'b0;
      slots_in_use    <= CFG_RESET;
      write_pointer   <= '0;
      handled_pointer <= '0;
      overrun_flag    <= 1'b0;
      cur             <= '0;
      cnt             <= '0;
    end else begin
      if (res_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end

      // Shrinking the ring pulls pointers beyond the new end back to slot zero.
      if (cfg_wr_en) begin
        slots_in_use <= cfg_wr_data;
        if (CNT_W'(write_pointer) >= cfg_n) begin
          write_pointer <= '0;
        end
        if (CNT_W'(handled_pointer) >= cfg_n) begin
          handled_pointer <= '0;
        end
      end

      case (state)
        IDLE: begin
          if (accept) begin
            case (op)
              OP_APPEND: begin
                write_pointer <= wp_adv;
                overrun_flag  <= ov_new;
                if (ov_new) begin
                  handled_pointer <= wp_adv;
                end
                out_kind  <= KIND_APPEND_DONE;
                out_slot  <= write_pointer;
                out_last  <= 1'b1;
              end
              OP_DRAIN_NEW: begin
                handled_pointer <= write_pointer;
                if (write_pointer > handled_pointer) begin
                  cur   <= handled_pointer;
                  cnt   <= CNT_W'(write_pointer) - CNT_W'(handled_pointer);
                  state <= RUN;
                end else if (drain_empty) begin
                  out_kind  <= KIND_EMPTY;
                  out_slot  <= '0;
                  out_last  <= 1'b1;
                end else begin
                  // Unhandled entries wrap past the end of the ring.
                  cur          <= handled_pointer;
                  cnt          <= (n + CNT_W'(write_pointer)) - CNT_W'(handled_pointer);
                  overrun_flag <= 1'b0;
                  state        <= RUN;
                end
              end
              OP_DRAIN_ALL: begin
                cur   <= write_pointer;
                cnt   <= n;
                state <= RUN;
              end
              OP_CLEAR: begin
                write_pointer   <= '0;
                handled_pointer <= '0;
                overrun_flag    <= 1'b0;
                out_kind        <= KIND_CLEAR_DONE;
                out_slot        <= '0;
                out_last        <= 1'b1;
              end
              default: begin
                state <= IDLE;
              end
            endcase
          end
        end
        RUN: begin
          // The store's read register is loaded on the same edge.
          if (out_free) begin
            out_kind  <= KIND_DRAINED;
            out_slot  <= cur;
            out_last  <= (cnt == CNT_W'(1));
            cur       <= ptr_advance(cur, n);
            cnt       <= cnt - CNT_W'(1);
            if (cnt == CNT_W'(1)) begin
              state <= IDLE;
            end
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

  always_comb begin
    out_data.result_kind = out_kind;
    out_data.slot        = SLOT_OUT_W'(out_slot);
    out_data.entry_out   = (out_kind == KIND_DRAINED) ? ENTRY_OUT_W'(rd_data) : '0;
    out_data.last_of_run = out_last;
  end

endmodule

### src/orld_checker.sv
// Port-level checker for the ring log drain, bound to the top level.
`include "assert_macros.svh"

module orld_checker import orld_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      in_valid,
  input logic      in_stall,
  input in_item_t  in_data,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_data
);

  `ORLD_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data), "stalled result changed")
  `ORLD_ASSERT(a_single_result, out_valid && out_data.result_kind != KIND_DRAINED |-> out_data.last_of_run && out_data.entry_out == '0, "non-drain result not alone or has data")
  `ORLD_ASSERT(a_slot_zero, out_valid && (out_data.result_kind == KIND_EMPTY || out_data.result_kind == KIND_CLEAR_DONE) |-> out_data.slot == '0, "empty or clear result has a slot")
  `ORLD_ASSERT_NEXT(a_append_result, in_valid && !in_stall && in_data.op == OP_APPEND, out_valid && out_data.result_kind == KIND_APPEND_DONE, "append did not report")

endmodule

bind overwriting_ring_log_drain orld_checker u_checker (.*);
